// File: hw/rtl/cinv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circle inversion package
// Word widths, pipeline depths and the structs passed between the stages.
// ----------------------------------------------------------------------------
package cinv_pkg;

    localparam int WORD_BITS = 32;
    localparam int RAD_BITS  = WORD_BITS - 1;
    localparam int MAG_BITS  = WORD_BITS + 1;
    localparam int SQ_BITS   = 2 * MAG_BITS;
    localparam int RSQ_BITS  = 2 * RAD_BITS;
    localparam int HALF_BITS = RAD_BITS;
    localparam int NUM_BITS  = RSQ_BITS + MAG_BITS;
    localparam int N_BITS    = NUM_BITS + 2;
    localparam int D_BITS    = SQ_BITS + 1;
    localparam int Q_BITS    = MAG_BITS;
    localparam int DIV_LAT   = Q_BITS + 2;
    localparam int FRONT_LAT = 4;
    localparam int BACK_LAT  = 3;
    localparam int PIPE_LAT  = FRONT_LAT + DIV_LAT + BACK_LAT;

    typedef struct packed {
        logic [WORD_BITS-1:0] cx;
        logic [WORD_BITS-1:0] cy;
        logic [WORD_BITS-1:0] ox;
        logic [WORD_BITS-1:0] oy;
        logic [RSQ_BITS-1:0]  r1sq;
        logic                 far;
        logic                 degen;
        logic                 neg_x;
        logic                 neg_y;
    } t_side;

    typedef struct packed {
        t_side                side;
        logic [NUM_BITS-1:0]  num_x;
        logic [NUM_BITS-1:0]  num_y;
        logic [NUM_BITS-1:0]  num_r;
        logic [SQ_BITS-1:0]   den;
    } t_front;

    typedef struct packed {
        logic [WORD_BITS-1:0] x;
        logic [WORD_BITS-1:0] y;
        logic [RAD_BITS-1:0]  r;
        logic                 keep;
        logic                 degen;
        logic                 sat;
    } t_result;

endpackage
`default_nettype wire

// File: hw/rtl/cinv_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circle inversion front end
// Four stages: offsets, squares, split numerator products, denominator.
// ----------------------------------------------------------------------------
module cinv_front (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [cinv_pkg::WORD_BITS-1:0]      i_cx,
    input  logic [cinv_pkg::WORD_BITS-1:0]      i_cy,
    input  logic [cinv_pkg::RAD_BITS-1:0]       i_r1,
    input  logic [cinv_pkg::WORD_BITS-1:0]      i_ox,
    input  logic [cinv_pkg::WORD_BITS-1:0]      i_oy,
    input  logic [cinv_pkg::RAD_BITS-1:0]       i_r2,
    output cinv_pkg::t_front                    o_front
);

    localparam int W   = cinv_pkg::WORD_BITS;
    localparam int RW  = cinv_pkg::RAD_BITS;
    localparam int MW  = cinv_pkg::MAG_BITS;
    localparam int SW  = cinv_pkg::SQ_BITS;
    localparam int RSW = cinv_pkg::RSQ_BITS;
    localparam int HW  = cinv_pkg::HALF_BITS;
    localparam int NW  = cinv_pkg::NUM_BITS;
    localparam int PW  = HW + MW;

    logic [MW-1:0]  r_dx, r_dy;
    logic [W-1:0]   r_s1_cx, r_s1_cy, r_s1_ox, r_s1_oy;
    logic [RW-1:0]  r_s1_r1, r_s1_r2;

    logic [MW-1:0]  n_adx, n_ady;
    logic [SW-1:0]  n_dx2, n_dy2;
    logic [RSW-1:0] n_r1sq, n_r2sq;
    logic [MW-1:0]  r_adx, r_ady;
    logic [SW-1:0]  r_dx2, r_dy2;
    logic [RSW-1:0] r_r1sq, r_r2sq;
    logic [RW-1:0]  r_s2_r1;
    logic [W-1:0]   r_s2_cx, r_s2_cy, r_s2_ox, r_s2_oy;
    logic           r_s2_nx, r_s2_ny;

    logic [RSW-HW-1:0] n_hi;
    logic [HW-1:0]     n_lo;
    logic [SW-1:0]     r_d2;
    logic [PW-1:0]     r_pxl, r_pxh, r_pyl, r_pyh, r_prl, r_prh;
    logic [RSW-1:0]    r_s3_r1sq, r_s3_r2sq;
    logic [W-1:0]      r_s3_cx, r_s3_cy, r_s3_ox, r_s3_oy;
    logic              r_s3_nx, r_s3_ny;

    logic              n_ge;
    logic [SW-1:0]     n_r1sq_w, n_r2sq_w;
    cinv_pkg::t_front  n_front, r_front;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx    <= {i_cx[W-1], i_cx} - {i_ox[W-1], i_ox};
            r_dy    <= {i_cy[W-1], i_cy} - {i_oy[W-1], i_oy};
            r_s1_cx <= i_cx;
            r_s1_cy <= i_cy;
            r_s1_ox <= i_ox;
            r_s1_oy <= i_oy;
            r_s1_r1 <= i_r1;
            r_s1_r2 <= i_r2;
        end
    end

    assign n_adx  = r_dx[MW-1] ? (MW'(0) - r_dx) : r_dx;
    assign n_ady  = r_dy[MW-1] ? (MW'(0) - r_dy) : r_dy;
    assign n_dx2  = SW'(n_adx) * SW'(n_adx);
    assign n_dy2  = SW'(n_ady) * SW'(n_ady);
    assign n_r1sq = RSW'(r_s1_r1) * RSW'(r_s1_r1);
    assign n_r2sq = RSW'(r_s1_r2) * RSW'(r_s1_r2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_adx   <= n_adx;
            r_ady   <= n_ady;
            r_dx2   <= n_dx2;
            r_dy2   <= n_dy2;
            r_r1sq  <= n_r1sq;
            r_r2sq  <= n_r2sq;
            r_s2_r1 <= r_s1_r1;
            r_s2_cx <= r_s1_cx;
            r_s2_cy <= r_s1_cy;
            r_s2_ox <= r_s1_ox;
            r_s2_oy <= r_s1_oy;
            r_s2_nx <= r_dx[MW-1];
            r_s2_ny <= r_dy[MW-1];
        end
    end

    assign n_lo = r_r2sq[HW-1:0];
    assign n_hi = r_r2sq[RSW-1:HW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d2      <= r_dx2 + r_dy2;
            r_pxl     <= PW'(n_lo) * PW'(r_adx);
            r_pxh     <= PW'(n_hi) * PW'(r_adx);
            r_pyl     <= PW'(n_lo) * PW'(r_ady);
            r_pyh     <= PW'(n_hi) * PW'(r_ady);
            r_prl     <= PW'(n_lo) * PW'(r_s2_r1);
            r_prh     <= PW'(n_hi) * PW'(r_s2_r1);
            r_s3_r1sq <= r_r1sq;
            r_s3_r2sq <= r_r2sq;
            r_s3_cx   <= r_s2_cx;
            r_s3_cy   <= r_s2_cy;
            r_s3_ox   <= r_s2_ox;
            r_s3_oy   <= r_s2_oy;
            r_s3_nx   <= r_s2_nx;
            r_s3_ny   <= r_s2_ny;
        end
    end

    assign n_r1sq_w = SW'(r_s3_r1sq);
    assign n_r2sq_w = SW'(r_s3_r2sq);
    assign n_ge     = r_d2 >= n_r1sq_w;

    always_comb begin
        n_front            = r_front;
        n_front.side.cx    = r_s3_cx;
        n_front.side.cy    = r_s3_cy;
        n_front.side.ox    = r_s3_ox;
        n_front.side.oy    = r_s3_oy;
        n_front.side.r1sq  = r_s3_r1sq;
        n_front.side.far   = r_d2 > n_r2sq_w;
        n_front.side.degen = r_d2 == n_r1sq_w;
        n_front.side.neg_x = r_s3_nx ^ ~n_ge;
        n_front.side.neg_y = r_s3_ny ^ ~n_ge;
        n_front.num_x      = (NW'(r_pxh) << HW) + NW'(r_pxl);
        n_front.num_y      = (NW'(r_pyh) << HW) + NW'(r_pyl);
        n_front.num_r      = (NW'(r_prh) << HW) + NW'(r_prl);
        n_front.den        = n_ge ? (r_d2 - n_r1sq_w) : (n_r1sq_w - r_d2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_front <= n_front;
        end
    end

    assign o_front = r_front;

endmodule
`default_nettype wire

// File: hw/rtl/cinv_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circle inversion divider
// Pipelined restoring divider, one quotient bit per stage, rounded to nearest.
// ----------------------------------------------------------------------------
module cinv_div (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [cinv_pkg::NUM_BITS-1:0]    i_num,
    input  logic [cinv_pkg::SQ_BITS-1:0]     i_den,
    output logic [cinv_pkg::Q_BITS-1:0]      o_quo,
    output logic                             o_ovf
);

    localparam int NB = cinv_pkg::N_BITS;
    localparam int DW = cinv_pkg::D_BITS;
    localparam int QW = cinv_pkg::Q_BITS;

    logic [NB-1:0] r_n;
    logic [DW-1:0] r_d;
    logic [DW-1:0] r_rem [0:QW];
    logic [DW-1:0] r_dv  [0:QW];
    logic [QW-1:0] r_lq  [0:QW];
    logic          r_ovf [0:QW];

    // Rounding: floor((2*num + den) / (2*den)).
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n <= NB'({i_num, 1'b0}) + NB'(i_den);
            r_d <= {i_den, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= DW'(r_n[NB-1:QW]) >= r_d;
            r_rem[0] <= DW'(r_n[NB-1:QW]);
            r_dv[0]  <= r_d;
            r_lq[0]  <= r_n[QW-1:0];
        end
    end

    for (genvar g = 0; g < QW; g++) begin : g_step
        logic [DW:0] n_t;
        logic [DW:0] n_diff;
        logic        n_ge;

        assign n_t    = {r_rem[g], r_lq[g][QW-1]};
        assign n_diff = n_t - {1'b0, r_dv[g]};
        assign n_ge   = n_t >= {1'b0, r_dv[g]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1] <= n_ge ? n_diff[DW-1:0] : n_t[DW-1:0];
                r_lq[g+1]  <= {r_lq[g][QW-2:0], n_ge};
                r_dv[g+1]  <= r_dv[g];
                r_ovf[g+1] <= r_ovf[g];
            end
        end
    end

    assign o_quo = r_lq[QW];
    assign o_ovf = r_ovf[QW];

endmodule
`default_nettype wire

// File: hw/rtl/cinv_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circle inversion back end
// Three stages: offset and clipping, movement squares, keep test and result.
// ----------------------------------------------------------------------------
module cinv_back (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [cinv_pkg::Q_BITS-1:0]   i_qx,
    input  logic                          i_ovx,
    input  logic [cinv_pkg::Q_BITS-1:0]   i_qy,
    input  logic                          i_ovy,
    input  logic [cinv_pkg::Q_BITS-1:0]   i_qr,
    input  logic                          i_ovr,
    input  cinv_pkg::t_side               i_side,
    output cinv_pkg::t_result             o_result
);

    localparam int W  = cinv_pkg::WORD_BITS;
    localparam int RW = cinv_pkg::RAD_BITS;
    localparam int MW = cinv_pkg::MAG_BITS;
    localparam int SW = cinv_pkg::SQ_BITS;
    localparam int QW = cinv_pkg::Q_BITS;
    localparam int VW = W + 3;

    function automatic logic [W:0] f_clip(input logic [VW-1:0] v);
        logic same;
        same = v[VW-1:W-1] == {(VW - W + 1){v[VW-1]}};
        if (same) begin
            return {1'b0, v[W-1:0]};
        end else if (v[VW-1]) begin
            return {1'b1, 1'b1, {(W - 1){1'b0}}};
        end else begin
            return {1'b1, 1'b0, {(W - 1){1'b1}}};
        end
    endfunction

    logic [QW:0]   n_sx, n_sy;
    logic [VW-1:0] n_bx, n_by, n_vx, n_vy;
    logic [W:0]    n_cx, n_cy;
    logic          n_rbig;

    logic [W-1:0]  r_ix, r_iy;
    logic [RW-1:0] r_ir;
    logic          r_sat;
    cinv_pkg::t_side r_a_side;

    logic [MW-1:0] n_ex, n_ey, n_aex, n_aey;
    logic [SW-1:0] r_ex2, r_ey2;
    logic [W-1:0]  r_b_ix, r_b_iy;
    logic [RW-1:0] r_b_ir;
    logic          r_b_sat;
    cinv_pkg::t_side r_b_side;

    logic [SW-1:0]     n_mv;
    cinv_pkg::t_result n_res, r_res;

    assign n_sx = i_ovx ? {1'b1, {QW{1'b0}}} : {1'b0, i_qx};
    assign n_sy = i_ovy ? {1'b1, {QW{1'b0}}} : {1'b0, i_qy};
    assign n_bx = {{(VW - W){i_side.ox[W-1]}}, i_side.ox};
    assign n_by = {{(VW - W){i_side.oy[W-1]}}, i_side.oy};
    assign n_vx = i_side.neg_x ? (n_bx - VW'(n_sx)) : (n_bx + VW'(n_sx));
    assign n_vy = i_side.neg_y ? (n_by - VW'(n_sy)) : (n_by + VW'(n_sy));
    assign n_cx = f_clip(n_vx);
    assign n_cy = f_clip(n_vy);
    assign n_rbig = i_ovr || (i_qr[QW-1:RW] != '0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ix     <= n_cx[W-1:0];
            r_iy     <= n_cy[W-1:0];
            r_ir     <= n_rbig ? {RW{1'b1}} : i_qr[RW-1:0];
            r_sat    <= n_cx[W] | n_cy[W] | n_rbig;
            r_a_side <= i_side;
        end
    end

    assign n_ex  = {r_ix[W-1], r_ix} - {r_a_side.cx[W-1], r_a_side.cx};
    assign n_ey  = {r_iy[W-1], r_iy} - {r_a_side.cy[W-1], r_a_side.cy};
    assign n_aex = n_ex[MW-1] ? (MW'(0) - n_ex) : n_ex;
    assign n_aey = n_ey[MW-1] ? (MW'(0) - n_ey) : n_ey;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ex2    <= SW'(n_aex) * SW'(n_aex);
            r_ey2    <= SW'(n_aey) * SW'(n_aey);
            r_b_ix   <= r_ix;
            r_b_iy   <= r_iy;
            r_b_ir   <= r_ir;
            r_b_sat  <= r_sat;
            r_b_side <= r_a_side;
        end
    end

    assign n_mv = r_ex2 + r_ey2;

    always_comb begin
        if (r_b_side.degen) begin
            n_res = '0;
            n_res.degen = 1'b1;
        end else begin
            n_res.x     = r_b_ix;
            n_res.y     = r_b_iy;
            n_res.r     = r_b_ir;
            n_res.keep  = r_b_side.far && (n_mv > SW'(r_b_side.r1sq));
            n_res.degen = 1'b0;
            n_res.sat   = r_b_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_result = r_res;

endmodule
`default_nettype wire

// File: hw/rtl/cinv_obuf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circle inversion output buffer
// Two-entry queue that decouples the pipeline from the result handshake.
// ----------------------------------------------------------------------------
module cinv_obuf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  cinv_pkg::t_result    i_data,
    input  logic                 i_ready,
    output logic                 o_valid,
    output cinv_pkg::t_result    o_data,
    output logic                 o_full
);

    cinv_pkg::t_result r_mem [0:1];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       n_pop;

    assign o_valid = r_cnt != 2'd0;
    assign o_full  = r_cnt == 2'd2;
    assign o_data  = r_mem[r_rp];
    assign n_pop   = o_valid & i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (n_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, n_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    ap_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    ap_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !i_push)
        else $error("item pushed into a full output buffer");

endmodule
`default_nettype wire

// File: hw/rtl/circle_inversion.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Circle inversion
// Image of a circle under inversion in another circle, with keep test.
// Throughput: one item per cycle; the 35-stage divider sets the depth.
// The pipeline stalls only while the two-entry output buffer is full.
// Reset clears the valid bits and the output buffer; data is not reset.
// ----------------------------------------------------------------------------
module circle_inversion (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [cinv_pkg::WORD_BITS-1:0]   i_circle_x,
    input  logic signed [cinv_pkg::WORD_BITS-1:0]   i_circle_y,
    input  logic        [cinv_pkg::RAD_BITS-1:0]    i_circle_radius,
    input  logic signed [cinv_pkg::WORD_BITS-1:0]   i_centre_x,
    input  logic signed [cinv_pkg::WORD_BITS-1:0]   i_centre_y,
    input  logic        [cinv_pkg::RAD_BITS-1:0]    i_inversion_radius,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [cinv_pkg::WORD_BITS-1:0]   o_image_x,
    output logic signed [cinv_pkg::WORD_BITS-1:0]   o_image_y,
    output logic        [cinv_pkg::RAD_BITS-1:0]    o_image_radius,
    output logic                                    o_keep,
    output logic                                    o_degenerate,
    output logic                                    o_saturated
);

    localparam int PL = cinv_pkg::PIPE_LAT;
    localparam int DL = cinv_pkg::DIV_LAT;
    localparam int QW = cinv_pkg::Q_BITS;

    logic r_vld [0:PL-1];
    logic n_en, n_full;

    cinv_pkg::t_front  n_front;
    cinv_pkg::t_side   r_side [0:DL-1];
    cinv_pkg::t_result n_res, n_out;
    logic [QW-1:0]     n_qx, n_qy, n_qr;
    logic              n_ovx, n_ovy, n_ovr;

    assign n_en    = ~n_full;
    assign o_ready = n_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PL; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (n_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < PL; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    cinv_front u_front (
        .i_clk   (i_clk),
        .i_en    (n_en),
        .i_cx    (i_circle_x),
        .i_cy    (i_circle_y),
        .i_r1    (i_circle_radius),
        .i_ox    (i_centre_x),
        .i_oy    (i_centre_y),
        .i_r2    (i_inversion_radius),
        .o_front (n_front)
    );

    cinv_div u_div_x (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_num (n_front.num_x),
        .i_den (n_front.den),
        .o_quo (n_qx),
        .o_ovf (n_ovx)
    );

    cinv_div u_div_y (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_num (n_front.num_y),
        .i_den (n_front.den),
        .o_quo (n_qy),
        .o_ovf (n_ovy)
    );

    cinv_div u_div_r (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_num (n_front.num_r),
        .i_den (n_front.den),
        .o_quo (n_qr),
        .o_ovf (n_ovr)
    );

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_side[0] <= n_front.side;
            for (int k = 1; k < DL; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    cinv_back u_back (
        .i_clk    (i_clk),
        .i_en     (n_en),
        .i_qx     (n_qx),
        .i_ovx    (n_ovx),
        .i_qy     (n_qy),
        .i_ovy    (n_ovy),
        .i_qr     (n_qr),
        .i_ovr    (n_ovr),
        .i_side   (r_side[DL-1]),
        .o_result (n_res)
    );

    cinv_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (n_en & r_vld[PL-1]),
        .i_data  (n_res),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_data  (n_out),
        .o_full  (n_full)
    );

    assign o_image_x      = n_out.x;
    assign o_image_y      = n_out.y;
    assign o_image_radius = n_out.r;
    assign o_keep         = n_out.keep;
    assign o_degenerate   = n_out.degen;
    assign o_saturated    = n_out.sat;

    ap_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> (o_image_x == '0 && o_image_y == '0 &&
            o_image_radius == '0 && !o_keep && !o_saturated))
        else $error("degenerate item carries nonzero image fields");

endmodule
`default_nettype wire
